// ----- hdl/ssem_pkg.sv -----
// types, constants and microcode table for the ssem step core
// no dependencies; imported by the sequencer, the store and the top level
package ssem_pkg;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int OPC_LSB = 13;
  localparam int OPC_W   = 3;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [OPC_W-1:0] {
    OP_JMP     = 3'd0,
    OP_JRP     = 3'd1,
    OP_LDN     = 3'd2,
    OP_STO     = 3'd3,
    OP_SUB     = 3'd4,
    OP_SUB_ALT = 3'd5,
    OP_CMP     = 3'd6,
    OP_STP     = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    U_IDLE  = 4'd0,
    U_LOAD  = 4'd1,
    U_READ  = 4'd2,
    U_RCAP  = 4'd3,
    U_STEP  = 4'd4,
    U_INC   = 4'd5,
    U_FETCH = 4'd6,
    U_OPND  = 4'd7,
    U_EXEC  = 4'd8,
    U_RST   = 4'd9,
    U_OUT   = 4'd10
  } uaddr_t;

  typedef enum logic [1:0] {
    SQ_NEXT     = 2'd0,
    SQ_DISPATCH = 2'd1,
    SQ_HALT     = 2'd2
  } seq_t;

  typedef enum logic [1:0] {
    RS_HOST = 2'd0,
    RS_PC   = 2'd1,
    RS_OPND = 2'd2
  } rsel_t;

  typedef struct packed {
    rsel_t  rd_sel;
    logic   host_we;
    logic   rd_cap;
    logic   ir_cap;
    logic   pc_inc;
    logic   exec;
    logic   clr;
    logic   strobe;
    seq_t   seq;
    uaddr_t nxt;
    uaddr_t alt;
  } ctrl_t;

  function automatic uaddr_t cmd_entry(cmd_t c);
    uaddr_t e;
    unique case (c)
      CMD_LOAD:    e = U_LOAD;
      CMD_READ:    e = U_READ;
      CMD_STEP:    e = U_STEP;
      CMD_RESTART: e = U_RST;
      default:     e = U_IDLE;
    endcase
    return e;
  endfunction

  function automatic ctrl_t ucode_rom(uaddr_t a);
    ctrl_t w;
    w = '{rd_sel: RS_HOST, host_we: 1'b0, rd_cap: 1'b0, ir_cap: 1'b0, pc_inc: 1'b0,
          exec: 1'b0, clr: 1'b0, strobe: 1'b0, seq: SQ_NEXT, nxt: U_IDLE, alt: U_IDLE};
    unique case (a)
      U_IDLE:  w.seq = SQ_DISPATCH;
      U_LOAD:  begin w.host_we = 1'b1; w.nxt = U_OUT; end
      U_READ:  begin w.rd_sel = RS_HOST; w.nxt = U_RCAP; end
      U_RCAP:  begin w.rd_cap = 1'b1; w.nxt = U_OUT; end
      U_STEP:  begin w.seq = SQ_HALT; w.nxt = U_INC; w.alt = U_OUT; end
      U_INC:   begin w.pc_inc = 1'b1; w.nxt = U_FETCH; end
      U_FETCH: begin w.rd_sel = RS_PC; w.nxt = U_OPND; end
      U_OPND:  begin w.ir_cap = 1'b1; w.rd_sel = RS_OPND; w.nxt = U_EXEC; end
      U_EXEC:  begin w.exec = 1'b1; w.nxt = U_OUT; end
      U_RST:   begin w.clr = 1'b1; w.nxt = U_OUT; end
      U_OUT:   begin w.strobe = 1'b1; w.nxt = U_IDLE; end
      default: w.nxt = U_IDLE;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/ssem_store.sv -----
// 32-bit word store with registered read and per-word valid bits
// uses ssem_pkg for widths
module ssem_store #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [ssem_pkg::ADDR_W-1:0] waddr,
  input  logic [ssem_pkg::WORD_W-1:0] wdata,
  input  logic [ssem_pkg::ADDR_W-1:0] raddr,
  output logic [ssem_pkg::WORD_W-1:0] rdata
);
  import ssem_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
  end

  // unwritten words read as zero
  always_ff @(posedge clk) begin
    rdata_r <= vld_r[raddr[IW-1:0]] ? mem[raddr[IW-1:0]] : '0;
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/ssem_useq.sv -----
// microcode sequencer: step counter, dispatch on command, halt branch
// uses ssem_pkg for the control word and the microcode table
module ssem_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      cmd,
  input  logic            halted,
  output logic            busy,
  output ssem_pkg::ctrl_t cw
);
  import ssem_pkg::*;

  uaddr_t upc_r, upc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    cw      = ucode_rom(upc_r);
    upc_nxt = cw.nxt;
    unique case (cw.seq)
      SQ_DISPATCH: upc_nxt = start ? cmd_entry(cmd_t'(cmd)) : U_IDLE;
      SQ_HALT:     upc_nxt = halted ? cw.alt : cw.nxt;
      default:     upc_nxt = cw.nxt;
    endcase
  end

  assign busy = (upc_r != U_IDLE);

endmodule

// ----- hdl/ssem_cpu_step_core.sv -----
// top level of the ssem step core: command capture, datapath registers
// depends on ssem_pkg, ssem_useq and ssem_store
//
// one command word is taken at a clock edge with start high and busy low:
// in_cmd selects load word, read word, execute one instruction or restart,
// in_addr and in_data_word serve load and read. every command gives one
// result word on the out_ ports, marked by out_valid for one cycle; the
// receiver cannot hold it off. states after accept: U_LOAD for load,
// U_RST for restart, U_STEP for a step while halted, U_READ, U_RCAP for
// read, U_STEP, U_INC, U_FETCH, U_OPND, U_EXEC for an executed step; then
// the strobe state U_OUT. busy falls in the cycle after the strobe.
// a step runs as microcode: increment pc, fetch, operand read, execute,
// each paced by the single registered read port of the store.
// reset clears pc, accumulator, halt flag, instruction count and the
// store's valid bits, so the whole store reads as zero until written.
// restart clears the same registers but keeps the store.
module ssem_cpu_step_core #(
  parameter int MEM_WORDS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_cmd,
  input  logic [ssem_pkg::ADDR_W-1:0]       in_addr,
  input  logic signed [ssem_pkg::WORD_W-1:0] in_data_word,
  output logic                              out_valid,
  output logic [ssem_pkg::ADDR_W-1:0]       out_pc_out,
  output logic signed [ssem_pkg::WORD_W-1:0] out_acc_out,
  output logic signed [ssem_pkg::WORD_W-1:0] out_read_word,
  output logic                              out_halted,
  output logic [ssem_pkg::WORD_W-1:0]       out_op_count
);
  import ssem_pkg::*;

  ctrl_t             cw;
  logic              accept;

  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] data_r;
  opcode_t           opc_r;
  logic [ADDR_W-1:0] opd_r;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic              halted_r, halted_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  assign accept = start && !busy;

  ssem_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (in_cmd),
    .halted (halted_r),
    .busy   (busy),
    .cw     (cw)
  );

  ssem_store #(
    .DEPTH (MEM_WORDS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // store port steering
  assign mem_we    = cw.host_we || (cw.exec && (opc_r == OP_STO));
  assign mem_waddr = cw.host_we ? addr_r : opd_r;
  assign mem_wdata = cw.host_we ? data_r : acc_r;

  always_comb begin
    unique case (cw.rd_sel)
      RS_HOST: mem_raddr = addr_r;
      RS_PC:   mem_raddr = pc_r;
      RS_OPND: mem_raddr = mem_rdata[ADDR_W-1:0];
      default: mem_raddr = addr_r;
    endcase
  end

  // command capture and instruction register
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_addr;
      data_r <= in_data_word;
    end
    if (cw.ir_cap) begin
      opc_r <= opcode_t'(mem_rdata[OPC_LSB +: OPC_W]);
      opd_r <= mem_rdata[ADDR_W-1:0];
    end
    rd_r <= rd_nxt;
  end

  always_comb begin
    rd_nxt = rd_r;
    if (accept) begin
      rd_nxt = '0;
    end else if (cw.rd_cap) begin
      rd_nxt = mem_rdata;
    end
  end

  // execute
  always_comb begin
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    cnt_nxt    = cnt_r;
    if (cw.clr) begin
      pc_nxt     = '0;
      acc_nxt    = '0;
      halted_nxt = 1'b0;
      cnt_nxt    = '0;
    end
    if (cw.pc_inc) begin
      pc_nxt = pc_r + ADDR_W'(1);
    end
    if (cw.exec) begin
      cnt_nxt = cnt_r + WORD_W'(1);
      unique case (opc_r) inside
        OP_JMP:             pc_nxt = mem_rdata[ADDR_W-1:0];
        OP_JRP:             pc_nxt = pc_r + mem_rdata[ADDR_W-1:0];
        OP_LDN:             acc_nxt = WORD_W'(0) - mem_rdata;
        OP_STO:             acc_nxt = acc_r;
        OP_SUB, OP_SUB_ALT: acc_nxt = acc_r - mem_rdata;
        OP_CMP: begin
          if (acc_r[WORD_W-1]) begin
            pc_nxt  = pc_r + ADDR_W'(1);
            cnt_nxt = cnt_r + WORD_W'(2);
          end
        end
        OP_STP:             halted_nxt = 1'b1;
        default:            halted_nxt = halted_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      acc_r    <= '0;
      halted_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      pc_r     <= pc_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_valid     = cw.strobe;
  assign out_pc_out    = pc_r;
  assign out_acc_out   = acc_r;
  assign out_read_word = rd_r;
  assign out_halted    = halted_r;
  assign out_op_count  = cnt_r;

  // restart gives a cleared machine in the strobe state after U_RST
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_RESTART) |-> ##2
      (out_valid && (out_pc_out == '0) && (out_acc_out == '0) &&
       !out_halted && (out_op_count == '0)))
    else $error("restart result not cleared");

  // a load word is answered in the strobe state after U_LOAD
  a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_LOAD) |-> ##2 out_valid)
    else $error("load result missing");

  // the halt flag only drops through a restart
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(halted_r) |-> $past(cw.clr))
    else $error("halt flag cleared without restart");

endmodule
